// ===== hdl/artt_pkg.sv =====
// Shared package for the address range tag table.
// Holds the command codes, memory opcodes and the control/status structs
// that pass between the controller and the datapath. No dependencies.
package artt_pkg;

   localparam int unsigned OP_W     = 16;
   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned MODE_W   = 64;

   // request command codes
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_REGION = 1'b1;

   // memory access opcodes
   localparam logic [OP_W-1:0] OP_LOAD        = 16'd10;
   localparam logic [OP_W-1:0] OP_STORE       = 16'd11;
   localparam logic [OP_W-1:0] OP_LOAD_LINKED = 16'd12;
   localparam logic [OP_W-1:0] OP_STORE_COND  = 16'd13;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [MODE_W-1:0] mode_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // capture the accepted request
      logic start_scan;   // point the index at the newest entry
      logic read_ent;     // read the entry at the index
      logic step_idx;     // move to the next older entry
      logic finish_hit;   // build a matching result, update mode on a region request
      logic finish_miss;  // build a miss result, insert on a region request if the table is not full
      logic load_out;     // move the result into the output register
   } artt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_region;
      logic is_memop;
      logic empty;
      logic last;
      logic match;
      logic out_free;
   } artt_status_type;

endpackage

// ===== hdl/artt_dp.sv =====
// Datapath of the address range tag table: request registers, entry memories,
// fill count, scan index, compare logic and the output register.
// Depends on artt_pkg; driven by artt_ctrl through artt_cmd_type.
module artt_dp #(
   parameter int unsigned NUM_REGIONS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  artt_pkg::artt_cmd_type         cmd,
   output artt_pkg::artt_status_type      status,
   input  logic                           req_cmd,
   input  logic [artt_pkg::OP_W-1:0]      req_opcode,
   input  artt_pkg::addr_type             req_access_addr,
   input  artt_pkg::addr_type             req_region_begin,
   input  artt_pkg::addr_type             req_region_end,
   input  artt_pkg::mode_type             req_region_mode,
   input  logic                           csr_valid,
   input  artt_pkg::mode_type             csr_drop_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_forward,
   output artt_pkg::mode_type             rsp_tag,
   output logic                           rsp_hit,
   output logic                           rsp_table_full
);

   localparam int unsigned IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int unsigned CNT_W = $clog2(NUM_REGIONS + 1);

   // captured request
   logic                       cmd_ff;
   logic [artt_pkg::OP_W-1:0]  opcode_ff;
   artt_pkg::addr_type         addr_ff;
   artt_pkg::addr_type         begin_ff;
   artt_pkg::addr_type         end_ff;
   artt_pkg::mode_type         mode_ff;

   artt_pkg::mode_type         drop_mask_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [IDX_W-1:0]           idx_ff;
   logic [IDX_W-1:0]           idx_in;

   // entry storage
   artt_pkg::addr_type         mem_begin [NUM_REGIONS];
   artt_pkg::addr_type         mem_end   [NUM_REGIONS];
   artt_pkg::mode_type         mem_mode  [NUM_REGIONS];

   artt_pkg::addr_type         begin_rd_ff;
   artt_pkg::addr_type         end_rd_ff;
   artt_pkg::mode_type         mode_rd_ff;

   // staged result and output register
   logic                       res_fwd_ff;
   artt_pkg::mode_type         res_tag_ff;
   logic                       res_hit_ff;
   logic                       res_full_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_fwd_ff;
   artt_pkg::mode_type         rsp_tag_ff;
   logic                       rsp_hit_ff;
   logic                       rsp_full_ff;

   logic                       is_region;
   logic                       table_full;
   logic                       do_update;
   logic                       do_insert;
   logic [IDX_W-1:0]           wr_idx;

   assign is_region  = (cmd_ff == artt_pkg::CMD_REGION);
   assign table_full = (count_ff == CNT_W'(NUM_REGIONS));
   assign do_update  = cmd.finish_hit && is_region;
   assign do_insert  = cmd.finish_miss && is_region && !table_full;
   assign wr_idx     = do_update ? idx_ff : count_ff[IDX_W-1:0];

   always_comb begin
      status.is_region = is_region;
      status.is_memop  = (opcode_ff == artt_pkg::OP_LOAD)
                      || (opcode_ff == artt_pkg::OP_STORE)
                      || (opcode_ff == artt_pkg::OP_LOAD_LINKED)
                      || (opcode_ff == artt_pkg::OP_STORE_COND);
      status.empty     = (count_ff == '0);
      status.last      = (idx_ff == '0);
      if (is_region) begin
         status.match = (begin_rd_ff == begin_ff);
      end else begin
         status.match = (addr_ff >= begin_rd_ff) && (addr_ff < end_rd_ff);
      end
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start_scan) begin
         idx_in = IDX_W'(count_ff - CNT_W'(1));
      end else if (cmd.step_idx) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   assign count_in     = do_insert ? count_ff + CNT_W'(1) : count_ff;
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_mask_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            drop_mask_ff <= csr_drop_mask;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         cmd_ff    <= req_cmd;
         opcode_ff <= req_opcode;
         addr_ff   <= req_access_addr;
         begin_ff  <= req_region_begin;
         end_ff    <= req_region_end;
         mode_ff   <= req_region_mode;
      end
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_update || do_insert) begin
         mem_mode[wr_idx] <= mode_ff;
      end
      if (do_insert) begin
         mem_begin[wr_idx] <= begin_ff;
         mem_end[wr_idx]   <= end_ff;
      end
      if (cmd.read_ent) begin
         begin_rd_ff <= mem_begin[idx_ff];
         end_rd_ff   <= mem_end[idx_ff];
         mode_rd_ff  <= mem_mode[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_hit) begin
         res_fwd_ff  <= !is_region && ((mode_rd_ff & drop_mask_ff) == '0);
         res_tag_ff  <= is_region ? '0 : mode_rd_ff;
         res_hit_ff  <= 1'b1;
         res_full_ff <= 1'b0;
      end else if (cmd.finish_miss) begin
         res_fwd_ff  <= !is_region;
         res_tag_ff  <= '0;
         res_hit_ff  <= 1'b0;
         res_full_ff <= is_region && table_full;
      end
      if (cmd.load_out) begin
         rsp_fwd_ff  <= res_fwd_ff;
         rsp_tag_ff  <= res_tag_ff;
         rsp_hit_ff  <= res_hit_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_forward    = rsp_fwd_ff;
   assign rsp_tag        = rsp_tag_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

// ===== hdl/artt_ctrl.sv =====
// Controller of the address range tag table: sequences the newest-to-oldest
// scan over the entry memories and hands results to the output register.
// Depends on artt_pkg; drives artt_dp through artt_cmd_type.
module artt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  artt_pkg::artt_status_type  status,
   output artt_pkg::artt_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            // skip the scan for access requests with non-memory opcodes and for an empty table
            if ((!status.is_region && !status.is_memop) || status.empty) begin
               cmd.finish_miss = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            cmd.read_ent = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (status.match) begin
               cmd.finish_hit = 1'b1;
               state_in       = S_DONE;
            end else if (status.last) begin
               cmd.finish_miss = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.step_idx = 1'b1;
               state_in     = S_READ;
            end
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/address_range_tag_table.sv =====
// Top level of the address range tag table: joins artt_ctrl and artt_dp.
// Depends on artt_pkg, artt_ctrl and artt_dp.
//
//   port group  direction  handshake          carries
//   req_*       in         req_valid/stall    cmd, opcode, access_addr, region fields
//   rsp_*       out        rsp_valid/stall    forward, tag, hit, table_full
//   csr_*       in         csr_valid/ready    drop_mask
//
// One request at a time. With no scan needed (access request with a non-memory
// opcode, or empty table) it goes from S_START straight to S_DONE; otherwise the
// scan visits at most NUM_REGIONS entries, each in an S_READ memory read and an
// S_CHECK compare. The next request is taken while a result waits in the output
// register. Synchronous reset clears the table and drop_mask.
module address_range_tag_table #(
   parameter int unsigned NUM_REGIONS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [15:0]                req_opcode,
   input  logic [63:0]                req_access_addr,
   input  logic [63:0]                req_region_begin,
   input  logic [63:0]                req_region_end,
   input  logic [63:0]                req_region_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_forward,
   output logic [63:0]                rsp_tag,
   output logic                       rsp_hit,
   output logic                       rsp_table_full,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [63:0]                csr_drop_mask
);

   artt_pkg::artt_cmd_type    cmd;
   artt_pkg::artt_status_type status;

   assign csr_ready = 1'b1;

   artt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   artt_dp #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_opcode       (req_opcode),
      .req_access_addr  (req_access_addr),
      .req_region_begin (req_region_begin),
      .req_region_end   (req_region_end),
      .req_region_mode  (req_region_mode),
      .csr_valid        (csr_valid),
      .csr_drop_mask    (csr_drop_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_forward      (rsp_forward),
      .rsp_tag          (rsp_tag),
      .rsp_hit          (rsp_hit),
      .rsp_table_full   (rsp_table_full)
   );

   // an accepted request blocks the input until its result is moved into the output register
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted request");

   // a dropped insert reports no hit, no forward and no tag
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (!rsp_forward && !rsp_hit && rsp_tag == '0))
      else $error("table_full result carries other flags");

   // a result only leaves the controller when the output register is free
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a stalled response");

   // a response with a tag must be a hit
   a_tag_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tag != '0) |-> rsp_hit)
      else $error("nonzero tag without a hit");

endmodule
